### rtl/aes128_counter_mode_xcrypt_assert.svh
// Assertion macros used by the port-level checker of the counter-mode engine.
`ifndef AES128_COUNTER_MODE_XCRYPT_ASSERT_SVH
`define AES128_COUNTER_MODE_XCRYPT_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define AES_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

### rtl/aes_ctr_pkg.sv
// Package with shared types, constants and AES helper functions.
package aes_ctr_pkg;

  localparam int unsigned BlockBytes = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;
  localparam int unsigned RoundW     = 4;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_HIGH = 2'd0,
    REG_KEY_LOW  = 2'd1,
    REG_CTR_HIGH = 2'd2,
    REG_CTR_LOW  = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_OUT
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic reload;    // copy counter start registers into the counter
    logic load;      // load the AES state from the counter, key into round key
    logic round;     // run one AES round and step the round key
    logic bump;      // increment counter, mark keystream valid
    logic emit;      // capture the output byte and advance the byte position
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic last_round;
    logic need_block;
  } dp_stat_t;

  function automatic logic [7:0] sbox(input logic [7:0] x);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[x];
  endfunction

  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
  endfunction

  // Round constant for the key schedule step that produces round r (1..10).
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] v;
    case (r)
      4'd1:    v = 8'h01;
      4'd2:    v = 8'h02;
      4'd3:    v = 8'h04;
      4'd4:    v = 8'h08;
      4'd5:    v = 8'h10;
      4'd6:    v = 8'h20;
      4'd7:    v = 8'h40;
      4'd8:    v = 8'h80;
      4'd9:    v = 8'h1b;
      4'd10:   v = 8'h36;
      default: v = 8'h00;
    endcase
    return v;
  endfunction

endpackage

### rtl/aes128_counter_mode_xcrypt.sv
// Top level of the AES-128 counter-mode byte engine.
// A byte inside a keystream block goes from the idle state through the OUT state
// into the output register. A byte that opens a block (position 0, start flag, or
// first after reset) first takes one load and ten iterations of the shared AES round
// unit, which set the block cost. A new byte is taken only after the last is emitted.
// Reset (synchronous, active low) clears config, counter, position and handshakes.
module aes128_counter_mode_xcrypt (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aes_ctr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aes_ctr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,  // data_in
  input  logic                             in_tuser,  // message_start
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [7:0]                       out_tdata  // data_out
);
  import aes_ctr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  aes_ctr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_start   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  aes_ctr_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_in  (in_tuser),
    .byte_in   (in_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .byte_out  (out_tdata)
  );

endmodule

### rtl/aes_ctr_datapath.sv
// Datapath: configuration, counter, on-the-fly key schedule, AES round and byte XOR.
module aes_ctr_datapath (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aes_ctr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aes_ctr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                             start_in,
  input  logic [7:0]                       byte_in,
  input  aes_ctr_pkg::dp_cmd_t             cmd,
  output aes_ctr_pkg::dp_stat_t            stat,
  output logic [7:0]                       byte_out
);
  import aes_ctr_pkg::*;

  logic [63:0]  key_hi_r, key_lo_r, ctr_st_hi_r, ctr_st_lo_r;
  logic [127:0] ctr_r, ctr_nxt;
  logic [127:0] state_r, state_nxt;
  logic [127:0] rkey_r, rkey_nxt;
  logic [127:0] ks_r;
  logic [RoundW-1:0] round_r;
  logic [3:0]   pos_r;
  logic         ks_valid_r;
  logic [7:0]   out_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_hi_r    <= '0;
      key_lo_r    <= '0;
      ctr_st_hi_r <= '0;
      ctr_st_lo_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY_HIGH: key_hi_r    <= cfg_data;
        REG_KEY_LOW:  key_lo_r    <= cfg_data;
        REG_CTR_HIGH: ctr_st_hi_r <= cfg_data;
        REG_CTR_LOW:  ctr_st_lo_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Next round key: one key schedule step per round.
  logic [31:0] rot_w, sub_w;
  logic [31:0] w0, w1, w2, w3;
  always_comb begin
    rot_w = {rkey_r[23:0], rkey_r[31:24]};
    sub_w = {sbox(rot_w[31:24]), sbox(rot_w[23:16]), sbox(rot_w[15:8]), sbox(rot_w[7:0])};
    w0 = rkey_r[127:96] ^ sub_w ^ {rcon(round_r), 24'h0};
    w1 = rkey_r[95:64] ^ w0;
    w2 = rkey_r[63:32] ^ w1;
    w3 = rkey_r[31:0] ^ w2;
    rkey_nxt = {w0, w1, w2, w3};
  end

  // One AES round on the state; byte 0 sits in the top bits.
  logic [7:0] sb [16];
  logic [7:0] sr [16];
  logic [7:0] mc [16];
  logic [127:0] mc_vec;
  always_comb begin
    for (int i = 0; i < 16; i++) begin
      sb[i] = sbox(state_r[127-8*i -: 8]);
    end
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sr[c*4+r] = sb[((c + r) % 4) * 4 + r];
      end
    end
    for (int c = 0; c < 4; c++) begin
      logic [7:0] a0, a1, a2, a3, al;
      a0 = sr[c*4];
      a1 = sr[c*4+1];
      a2 = sr[c*4+2];
      a3 = sr[c*4+3];
      al = a0 ^ a1 ^ a2 ^ a3;
      mc[c*4]   = a0 ^ al ^ xtime(a0 ^ a1);
      mc[c*4+1] = a1 ^ al ^ xtime(a1 ^ a2);
      mc[c*4+2] = a2 ^ al ^ xtime(a2 ^ a3);
      mc[c*4+3] = a3 ^ al ^ xtime(a3 ^ a0);
    end
    for (int i = 0; i < 16; i++) begin
      mc_vec[127-8*i -: 8] = (round_r == 4'd10) ? sr[i] : mc[i];
    end
    state_nxt = mc_vec ^ rkey_nxt;
  end

  // Counter source: the start registers when the byte reloads.
  logic [127:0] ctr_cur;
  assign ctr_cur = cmd.reload ? {ctr_st_hi_r, ctr_st_lo_r} : ctr_r;
  assign ctr_nxt = ctr_r + 128'd1;

  // Control part of the datapath.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r      <= '0;
      pos_r      <= '0;
      ks_valid_r <= 1'b0;
      round_r    <= '0;
    end else begin
      if (cmd.reload) begin
        ctr_r      <= {ctr_st_hi_r, ctr_st_lo_r};
        pos_r      <= '0;
        ks_valid_r <= 1'b0;
      end
      if (cmd.load) begin
        round_r <= 4'd1;
      end else if (cmd.round) begin
        round_r <= round_r + 4'd1;
      end
      if (cmd.bump) begin
        ctr_r      <= ctr_nxt;
        ks_valid_r <= 1'b1;
      end
      if (cmd.emit) begin
        pos_r <= pos_r + 4'd1;
      end
    end
  end

  // AES state, round key and keystream payload; the keystream takes the final round output.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      state_r <= ctr_cur ^ {key_hi_r, key_lo_r};
      rkey_r  <= {key_hi_r, key_lo_r};
    end else if (cmd.round) begin
      state_r <= state_nxt;
      rkey_r  <= rkey_nxt;
    end
    if (cmd.bump) begin
      ks_r <= state_nxt;
    end
    if (cmd.emit) begin
      out_r <= byte_in ^ ks_r[127 - 8*pos_r -: 8];
    end
  end

  assign stat.last_round = (round_r == 4'd10);
  assign stat.need_block = start_in || !ks_valid_r || (pos_r == 4'd0);
  assign byte_out = out_r;

endmodule

### rtl/aes_ctr_ctrl.sv
// Controller: sequences the keystream computation and the stream handshakes.
module aes_ctr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic                  in_start,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  aes_ctr_pkg::dp_stat_t stat,
  output aes_ctr_pkg::dp_cmd_t  cmd
);
  import aes_ctr_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       take;

  // A byte is taken only in idle, and only when the output slot frees up.
  assign take = (state_r == ST_IDLE) && in_tvalid && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (take) state_nxt = stat.need_block ? ST_LOAD : ST_OUT;
      ST_LOAD:  state_nxt = ST_ROUND;
      ST_ROUND: if (stat.last_round) state_nxt = ST_OUT;
      ST_OUT:   if (!out_valid_r || out_tready) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Commands; the byte is held at the input until the OUT state consumes it.
  always_comb begin
    cmd           = '0;
    in_tready     = 1'b0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      ST_IDLE: begin
        if (take && in_start) cmd.reload = 1'b1;
      end
      ST_LOAD: begin
        cmd.load = 1'b1;
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        if (stat.last_round) cmd.bump = 1'b1;
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          cmd.emit      = 1'b1;
          in_tready     = 1'b1;
          out_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

### rtl/aes_ctr_checker.sv
// Port-level checker for the counter-mode engine, bound to the top level.
`include "aes128_counter_mode_xcrypt_assert.svh"
module aes_ctr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_tvalid,
  input logic       in_tready,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata
);
  `AES_ASSERT_IMPL(a_ready_needs_valid, clk, rst_n, in_tready, in_tvalid, "ready without valid")
  `AES_ASSERT_NEXT(a_take_gives_out, clk, rst_n, in_tvalid && in_tready, out_tvalid, "no result")
  `AES_ASSERT_NEXT(a_out_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")
  `AES_ASSERT_IMPL(a_no_overrun, clk, rst_n, in_tvalid && in_tready && out_tvalid, out_tready, "result overwritten")
endmodule

bind aes128_counter_mode_xcrypt aes_ctr_checker u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### tb/aes128_counter_mode_xcrypt_checker.sv
// Checker for the AES-128 counter-mode engine: keystream prediction and byte compare.
module aes128_counter_mode_xcrypt_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [aes_ctr_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [aes_ctr_pkg::CfgDataW-1:0] cfg_data,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [7:0]                       in_tdata,  // data_in
  input  logic                             in_tuser,  // message_start
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [7:0]                       out_tdata, // data_out
  output int                               fail_count,
  output int                               pending_bytes
);
  timeunit 1ns;
  timeprecision 1ps;
  import aes_ctr_pkg::*;

  logic [63:0] key_hi, key_lo, ctr_start_hi, ctr_start_lo;
  logic [127:0] ctr_block;
  logic [7:0] ks_bytes [16];
  logic [3:0] ks_pos;
  logic ks_valid;
  logic [7:0] expected_bytes [$];

  assign pending_bytes = expected_bytes.size();

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc, m;
    int i;
    acc = 0;
    m = a;
    for (i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ m;
      m = {m[6:0], 1'b0} ^ (m[7] ? 8'h1b : 8'h00);
    end
    return acc;
  endfunction

  function automatic logic [7:0] sub_byte(input logic [7:0] x);
    // Multiplicative inverse in GF(2^8) by x^254, then the affine map.
    logic [7:0] p, r, b, y;
    int i;
    p = x;
    r = 8'h01;
    for (i = 0; i < 8; i++) begin
      if (i != 0) r = gf_mul(r, p);
      p = gf_mul(p, p);
    end
    b = r;
    y = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]} ^ {b[3:0], b[7:4]} ^ 8'h63;
    return y;
  endfunction

  // Encrypt the counter block under the current key; state is column-major.
  function automatic void encrypt_counter(input logic [127:0] blk, input logic [127:0] key,
                                          output logic [7:0] s [16]);
    logic [31:0] w [44];
    logic [31:0] t;
    logic [7:0] u [16];
    logic [7:0] a0, a1, a2, a3, sum, rc;
    int i, r, c;
    for (i = 0; i < 4; i++) w[i] = key[127-32*i -: 32];
    rc = 8'h01;
    for (i = 4; i < 44; i++) begin
      t = w[i-1];
      if (i % 4 == 0) begin
        t = {t[23:0], t[31:24]};
        t = {sub_byte(t[31:24]) ^ rc, sub_byte(t[23:16]), sub_byte(t[15:8]), sub_byte(t[7:0])};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      w[i] = w[i-4] ^ t;
    end
    for (i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8] ^ w[i/4][31-8*(i%4) -: 8];
    for (r = 1; r <= 10; r++) begin
      for (i = 0; i < 16; i++) u[i] = sub_byte(s[i]);
      for (c = 0; c < 4; c++)
        for (i = 0; i < 4; i++) s[c*4+i] = u[((c+i)%4)*4+i];
      if (r != 10) begin
        for (c = 0; c < 4; c++) begin
          a0 = s[c*4]; a1 = s[c*4+1]; a2 = s[c*4+2]; a3 = s[c*4+3];
          sum = a0 ^ a1 ^ a2 ^ a3;
          s[c*4+0] = a0 ^ sum ^ gf_mul(a0 ^ a1, 8'h02);
          s[c*4+1] = a1 ^ sum ^ gf_mul(a1 ^ a2, 8'h02);
          s[c*4+2] = a2 ^ sum ^ gf_mul(a2 ^ a3, 8'h02);
          s[c*4+3] = a3 ^ sum ^ gf_mul(a3 ^ a0, 8'h02);
        end
      end
      for (i = 0; i < 16; i++) s[i] = s[i] ^ w[r*4 + i/4][31-8*(i%4) -: 8];
    end
  endfunction

  // Track registers, predict each accepted byte, compare each output transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      key_hi <= '0; key_lo <= '0; ctr_start_hi <= '0; ctr_start_lo <= '0;
      ctr_block = '0;
      ks_pos = '0;
      ks_valid = 1'b0;
      fail_count <= 0;
      expected_bytes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_KEY_HIGH: key_hi <= cfg_data;
          REG_KEY_LOW:  key_lo <= cfg_data;
          REG_CTR_HIGH: ctr_start_hi <= cfg_data;
          REG_CTR_LOW:  ctr_start_lo <= cfg_data;
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tuser) begin
          ctr_block = {ctr_start_hi, ctr_start_lo};
          ks_pos = '0;
          ks_valid = 1'b0;
        end
        if (!ks_valid || ks_pos == 0) begin
          encrypt_counter(ctr_block, {key_hi, key_lo}, ks_bytes);
          ctr_block = ctr_block + 128'd1;
          ks_valid = 1'b1;
        end
        expected_bytes.push_back(in_tdata ^ ks_bytes[ks_pos]);
        ks_pos = ks_pos + 4'd1;
      end
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output transfer, actual %02h", $time, out_tdata);
          fail_count <= fail_count + 1;
        end else if (expected_bytes[0] !== out_tdata) begin
          $display("%0t: data_out mismatch, expected %02h actual %02h",
                   $time, expected_bytes[0], out_tdata);
          fail_count <= fail_count + 1;
          void'(expected_bytes.pop_front());
        end else begin
          void'(expected_bytes.pop_front());
        end
      end
    end
  end
endmodule

### tb/tb_aes128_counter_mode_xcrypt.sv
// Testbench top: stimulus, configuration phases and verdict for the counter-mode engine.
module tb_aes128_counter_mode_xcrypt;
  timeunit 1ns;
  timeprecision 1ps;
  import aes_ctr_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [7:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [7:0] out_tdata;
  int fail_count;
  int pending_bytes;
  bit busy_phase = 1'b1;

  always #5 clk = ~clk;

  aes128_counter_mode_xcrypt u_top (.*);

  aes128_counter_mode_xcrypt_checker u_checker (.*);

  // Receiver stalls at random except during the no-idle stretch.
  always @(posedge clk) begin
    out_tready <= busy_phase ? ($urandom_range(99) >= 37) : 1'b1;
  end

  task automatic write_reg(input cfg_reg_t idx, input logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input logic [63:0] k0, k1, c0, c1);
    write_reg(REG_KEY_HIGH, k0);
    write_reg(REG_KEY_LOW, k1);
    write_reg(REG_CTR_HIGH, c0);
    write_reg(REG_CTR_LOW, c1);
  endtask

  // One byte transfer, with a random idle gap before it when idling is on.
  task automatic send_byte(input logic [7:0] d, input logic start);
    while (busy_phase && $urandom_range(99) < 37) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_bytes != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_messages(input int count);
    int n, len, i;
    n = 0;
    while (n < count) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(80, 40) : $urandom_range(40, 1);
      for (i = 0; i < len && n < count; i++) begin
        send_byte(8'($urandom), (i == 0) ? 1'b1 : ($urandom_range(49) == 0));
        n++;
      end
    end
  endtask

  initial begin
    int i;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // No start flag after reset: runs from a zero counter and zero key.
    for (i = 0; i < 18; i++) send_byte((i % 2) ? 8'hff : 8'h00, 1'b0);
    // Start flag mid-block discards the rest of the keystream block.
    send_byte(8'ha5, 1'b1);
    send_byte(8'h5a, 1'b0);
    drain();
    // Counter wrap from all ones minus one, with an all-ones key.
    set_config('1, '1, '1, 64'hffff_ffff_ffff_fffe);
    for (i = 0; i < 40; i++) send_byte(8'($urandom), i == 0);
    drain();
    // Key changed mid-message takes effect at the next block.
    set_config(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
               64'hf0f1f2f3f4f5f6f7, 64'hf8f9fafbfcfdfeff);
    for (i = 0; i < 8; i++) send_byte(8'($urandom), i == 0);
    drain();
    write_reg(REG_KEY_LOW, 64'h0);
    for (i = 0; i < 12; i++) send_byte(8'($urandom), 1'b0);
    drain();
    // Random phases with fresh settings.
    for (i = 0; i < 6; i++) begin
      set_config({$urandom, $urandom}, {$urandom, $urandom},
                 {$urandom, $urandom}, (i == 2) ? 64'hffff_ffff_ffff_fff0 : {$urandom, $urandom});
      busy_phase = (i != 3);
      send_messages(300);
      drain();
    end
    busy_phase = 1'b1;
    if (fail_count == 0) begin
      $display("[aes128_counter_mode_xcrypt] OK");
    end else begin
      $display("[aes128_counter_mode_xcrypt] ERROR");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("[aes128_counter_mode_xcrypt] ERROR");
    $finish;
  end
endmodule
